[design/flba_pkg.sv]
// Shared constants and transaction types for the free-list block allocator.
`default_nettype none

package flba_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;

	typedef struct packed {
		logic             command;
		logic [IDX_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] granted_index;
		logic [CNT_W-1:0] free_count;
	} rsp_t;

endpackage

`default_nettype wire

[design/free_list_block_allocator.sv]
// Top level of the free-list block allocator: LIFO block index pool.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_ready  | command, block_index
//   rsp     | out       | rsp_valid/rsp_ready  | status, granted_index, free_count
//   cfg     | in        | cfg_we               | cfg_wdata (pool size)
//
// A free, an allocate of an untouched block or a rejected command has its result
// registered straight from the request. An allocate served from the freed-index stack
// goes through the stack RAM's registered read first: rd_data_q, then the result register.
// Reset (or a cfg write) empties the freed stack and sets the untouched count to
// the pool size; no clearing pass is needed. A new request is taken only when no stack
// read is pending and the result register is empty or being drained in the same cycle.
`default_nettype none

module free_list_block_allocator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output      logic                            req_ready,
	input  wire flba_pkg::req_t                  req,
	output      logic                            rsp_valid,
	input  wire logic                            rsp_ready,
	output      flba_pkg::rsp_t                  rsp,
	input  wire logic                            cfg_we,
	input  wire logic [flba_pkg::CNT_W-1:0]      cfg_wdata
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_POP  = 1'b1;

	localparam logic [flba_pkg::CNT_W-1:0] MAX_CNT = flba_pkg::CNT_W'(flba_pkg::MAX_BLOCKS);

	logic                        state_q;
	logic [flba_pkg::CNT_W-1:0]  pool_q;
	logic [flba_pkg::CNT_W-1:0]  untouched_q;
	logic [flba_pkg::CNT_W-1:0]  depth_q;
	logic                        rsp_valid_q;
	flba_pkg::rsp_t              rsp_q;

	logic [flba_pkg::IDX_W-1:0]  stack_mem [flba_pkg::MAX_BLOCKS];
	logic [flba_pkg::IDX_W-1:0]  rd_data_q;

	logic                        accept;
	logic [flba_pkg::CNT_W-1:0]  free_total;
	logic [flba_pkg::CNT_W-1:0]  cfg_sat;
	logic [flba_pkg::CNT_W-1:0]  depth_dec;
	logic [flba_pkg::CNT_W-1:0]  untouched_dec;
	logic                        free_bad;
	logic                        push_en;
	logic                        pop_en;

	assign req_ready     = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept        = req_valid && req_ready;
	assign free_total    = untouched_q + depth_q;
	assign cfg_sat       = (cfg_wdata > MAX_CNT) ? MAX_CNT : cfg_wdata;
	assign depth_dec     = depth_q - flba_pkg::CNT_W'(1);
	assign untouched_dec = untouched_q - flba_pkg::CNT_W'(1);
	assign free_bad      = ({1'b0, req.block_index} >= pool_q) || (free_total >= pool_q)
	                       || (depth_q >= MAX_CNT);
	assign push_en       = accept && (req.command == flba_pkg::CMD_FREE) && !free_bad;
	assign pop_en        = accept && (req.command == flba_pkg::CMD_ALLOC) && (depth_q != '0);

	// Freed-index stack: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[depth_q[flba_pkg::IDX_W-1:0]] <= req.block_index;
		end
		if (pop_en) begin
			rd_data_q <= stack_mem[depth_dec[flba_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pool_q      <= MAX_CNT;
			untouched_q <= MAX_CNT;
			depth_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_q      <= cfg_sat;
				untouched_q <= cfg_sat;
				depth_q     <= '0;
			end else if (accept) begin
				if (req.command == flba_pkg::CMD_ALLOC) begin
					if (depth_q != '0) begin
						depth_q <= depth_dec;
					end else if (untouched_q != '0) begin
						untouched_q <= untouched_dec;
					end
				end else if (!free_bad) begin
					depth_q <= depth_q + flba_pkg::CNT_W'(1);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_en) begin
						// wait in S_POP for the stack read
						state_q     <= S_POP;
						rsp_valid_q <= 1'b0;
					end else if (accept) begin
						rsp_valid_q <= 1'b1;
					end else if (rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				S_POP: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload; no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.command == flba_pkg::CMD_ALLOC) begin
						if (untouched_q != '0) begin
							rsp_q.status        <= flba_pkg::ST_OK;
							rsp_q.granted_index <= untouched_dec[flba_pkg::IDX_W-1:0];
							rsp_q.free_count    <= free_total - flba_pkg::CNT_W'(1);
						end else begin
							rsp_q.status        <= flba_pkg::ST_EMPTY;
							rsp_q.granted_index <= '0;
							rsp_q.free_count    <= free_total;
						end
					end else begin
						rsp_q.status        <= free_bad ? flba_pkg::ST_BAD : flba_pkg::ST_OK;
						rsp_q.granted_index <= '0;
						rsp_q.free_count    <= free_bad ? free_total
						                                : free_total + flba_pkg::CNT_W'(1);
					end
				end
			end
			S_POP: begin
				rsp_q.status        <= flba_pkg::ST_OK;
				rsp_q.granted_index <= rd_data_q;
				rsp_q.free_count    <= free_total;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the free-list block allocator: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 100000;

	logic                           clk;
	logic                           arst_n;
	logic                           req_valid;
	logic                           req_ready;
	flba_pkg::req_t                 req;
	logic                           rsp_valid;
	logic                           rsp_ready = 1'b1;
	flba_pkg::rsp_t                 rsp;
	logic                           cfg_we;
	logic [flba_pkg::CNT_W-1:0]     cfg_wdata;

	// Shadow of the allocator: pool size register, freed-index stack, untouched count
	logic [flba_pkg::CNT_W-1:0]     size_reg;
	logic [flba_pkg::IDX_W-1:0]     lifo_mem [flba_pkg::MAX_BLOCKS];
	int unsigned                    freed_top;
	int unsigned                    fresh_left;
	logic [flba_pkg::IDX_W-1:0]     held_blocks [$];
	flba_pkg::rsp_t                 want_rsp [$];

	int                             err_cnt = 0;
	int                             cycle_cnt = 0;
	int                             stall_left = 0;
	bit                             quiet = 1'b0;

	free_list_block_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver back-pressure: unless quiet is set, drop ready for a burst of random length now and then
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready  <= (stall_left == 1);
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 5);
			rsp_ready  <= 1'b0;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		flba_pkg::rsp_t exp_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (want_rsp.size() == 0) begin
				report_mismatch("unexpected result, status", rsp.status, -1);
			end else begin
				exp_rsp = want_rsp.pop_front();
				if (rsp.status !== exp_rsp.status)
					report_mismatch("status", rsp.status, exp_rsp.status);
				if (rsp.granted_index !== exp_rsp.granted_index)
					report_mismatch("granted_index", rsp.granted_index, exp_rsp.granted_index);
				if (rsp.free_count !== exp_rsp.free_count)
					report_mismatch("free_count", rsp.free_count, exp_rsp.free_count);
			end
		end
	end

	function automatic int unsigned pool_cap();
		return (size_reg > flba_pkg::MAX_BLOCKS) ? flba_pkg::MAX_BLOCKS : size_reg;
	endfunction

	// Apply one accepted command to the shadow pool and work out its result
	task automatic advance_pool(input flba_pkg::req_t c, output flba_pkg::rsp_t r);
		bit found;
		r = '0;
		r.status = flba_pkg::ST_OK;
		if (c.command == flba_pkg::CMD_ALLOC) begin
			if (freed_top > 0) begin
				freed_top--;
				r.granted_index = lifo_mem[freed_top];
			end else if (fresh_left > 0) begin
				fresh_left--;
				r.granted_index = flba_pkg::IDX_W'(fresh_left);
			end else begin
				r.status = flba_pkg::ST_EMPTY;
			end
			if (r.status == flba_pkg::ST_OK)
				held_blocks.push_back(r.granted_index);
		end else begin
			if (c.block_index >= pool_cap() || fresh_left + freed_top >= pool_cap() ||
					freed_top >= flba_pkg::MAX_BLOCKS) begin
				r.status = flba_pkg::ST_BAD;
			end else begin
				lifo_mem[freed_top] = c.block_index;
				freed_top++;
				found = 1'b0;
				for (int i = 0; i < held_blocks.size() && !found; i++) begin
					if (held_blocks[i] == c.block_index) begin
						held_blocks.delete(i);
						found = 1'b1;
					end
				end
			end
		end
		r.free_count = flba_pkg::CNT_W'(fresh_left + freed_top);
	endtask

	// Send one command; record its expected result on the transaction
	task automatic send_command(input logic cmd, input int unsigned idx);
		flba_pkg::rsp_t exp_rsp;
		flba_pkg::req_t c;
		c.command     = cmd;
		c.block_index = flba_pkg::IDX_W'(idx);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req       <= c;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		advance_pool(c, exp_rsp);
		want_rsp.push_back(exp_rsp);
	endtask

	task automatic wait_all_answered();
		req_valid <= 1'b0;
		@(posedge clk);
		while (want_rsp.size() != 0) @(posedge clk);
		// allow for a stack read still in flight
		repeat (4) @(posedge clk);
	endtask

	task automatic set_pool_size(input int unsigned n);
		wait_all_answered();
		cfg_wdata <= flba_pkg::CNT_W'(n);
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		size_reg   = flba_pkg::CNT_W'(n);
		fresh_left = pool_cap();
		freed_top  = 0;
		held_blocks.delete();
	endtask

	// Mostly frees of blocks actually handed out; the rest is bogus or over-free noise
	task automatic run_random(input int n);
		int alloc_pct;
		int pos;
		logic cmd;
		int unsigned idx;
		alloc_pct = 50;
		for (int k = 0; k < n; k++) begin
			if (k % 20 == 0) begin
				case ($urandom_range(0, 2))
					0:       alloc_pct = 85;
					1:       alloc_pct = 15;
					default: alloc_pct = 50;
				endcase
			end
			idx = $urandom_range(0, flba_pkg::MAX_BLOCKS - 1);
			cmd = flba_pkg::CMD_ALLOC;
			if ($urandom_range(0, 99) >= alloc_pct) begin
				cmd = flba_pkg::CMD_FREE;
				if (held_blocks.size() != 0 && $urandom_range(0, 7) != 0) begin
					pos = $urandom_range(0, held_blocks.size() - 1);
					idx = held_blocks[pos];
				end else if ($urandom_range(0, 1) == 0 && pool_cap() < flba_pkg::MAX_BLOCKS) begin
					idx = pool_cap();
				end
			end
			send_command(cmd, idx);
		end
	endtask

	task automatic test_default_pool();
		send_command(flba_pkg::CMD_ALLOC, 0);
		send_command(flba_pkg::CMD_FREE, 1023);
		send_command(flba_pkg::CMD_FREE, 0);
		send_command(flba_pkg::CMD_ALLOC, 1023);
		send_command(flba_pkg::CMD_ALLOC, 0);
	endtask

	task automatic test_small_pool();
		set_pool_size(3);
		send_command(flba_pkg::CMD_FREE, 3);
		send_command(flba_pkg::CMD_ALLOC, 0);
		send_command(flba_pkg::CMD_ALLOC, 0);
		send_command(flba_pkg::CMD_ALLOC, 0);
		send_command(flba_pkg::CMD_ALLOC, 0);
		send_command(flba_pkg::CMD_FREE, 1023);
		send_command(flba_pkg::CMD_FREE, 0);
		send_command(flba_pkg::CMD_FREE, 0);
		send_command(flba_pkg::CMD_ALLOC, 0);
		send_command(flba_pkg::CMD_ALLOC, 0);
		send_command(flba_pkg::CMD_FREE, 2);
	endtask

	task automatic test_empty_pool();
		set_pool_size(0);
		send_command(flba_pkg::CMD_ALLOC, 0);
		send_command(flba_pkg::CMD_FREE, 0);
	endtask

	task automatic test_single_block();
		set_pool_size(1);
		send_command(flba_pkg::CMD_ALLOC, 0);
		send_command(flba_pkg::CMD_FREE, 0);
		send_command(flba_pkg::CMD_FREE, 0);
	endtask

	task automatic test_oversize_pool();
		set_pool_size(2047);
		send_command(flba_pkg::CMD_FREE, 1023);
		send_command(flba_pkg::CMD_ALLOC, 0);
	endtask

	task automatic test_random_traffic();
		set_pool_size(1024);
		run_random(130);
		set_pool_size(7);
		run_random(90);
		set_pool_size(33);
		run_random(120);
		set_pool_size(1100);
		run_random(60);
	endtask

	task automatic test_quiet_tail();
		set_pool_size($urandom_range(1, 64));
		quiet = 1'b1;
		run_random(110);
	endtask

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		size_reg   = flba_pkg::CNT_W'(flba_pkg::MAX_BLOCKS);
		fresh_left = flba_pkg::MAX_BLOCKS;
		freed_top  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_pool();
		test_small_pool();
		test_empty_pool();
		test_single_block();
		test_oversize_pool();
		test_random_traffic();
		test_quiet_tail();

		wait_all_answered();
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
